/* rtl/swm_pkg.sv */
package swm_pkg;

  localparam int unsigned WINDOW_DEPTH = 64;
  localparam int unsigned IDX_W = $clog2(WINDOW_DEPTH);
  localparam int unsigned CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned ENTRIES_W = 7;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_COUNT,
    IDX_ZERO,
    IDX_INC,
    IDX_DEC
  } idx_op_t;

  typedef enum logic [1:0] {
    RA_PREV,
    RA_CUR,
    RA_NEXT,
    RA_HALF
  } raddr_sel_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC,
    CNT_CLR
  } cnt_op_t;

  typedef enum logic {
    WD_VALUE,
    WD_RDATA
  } wdata_sel_t;

  typedef struct packed {
    logic       load;
    idx_op_t    idx_op;
    logic       rd_en;
    raddr_sel_t rd_sel;
    logic       wr_en;
    wdata_sel_t wd_sel;
    cnt_op_t    cnt_op;
    logic       out_load;
    logic [1:0] out_status;
  } ctl_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       full;
    logic       empty;
    logic       idx_zero;
    logic       idx_last;
    logic       rd_gt;
    logic       rd_ge;
    logic       out_busy;
  } stat_t;

endpackage

/* rtl/swm_ctrl.sv */
module swm_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  swm_pkg::stat_t stat,
  output swm_pkg::ctl_t  ctl
);
  import swm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_INS_CHK,
    S_INS_CMP,
    S_REM_RD,
    S_REM_CMP,
    S_SH_CHK,
    S_SH_WR,
    S_MED_RD,
    S_MED_WAIT
  } state_t;

  state_t     state, state_next;
  logic [1:0] status_code, status_code_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next       = state;
    status_code_next = status_code;
    ctl              = '0;
    ctl.idx_op       = IDX_HOLD;
    ctl.rd_sel       = RA_CUR;
    ctl.wd_sel       = WD_VALUE;
    ctl.cnt_op       = CNT_HOLD;
    ctl.out_status   = status_code;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        status_code_next = ST_OK;
        state_next       = S_MED_RD;
        unique case (stat.cmd)
          CMD_INSERT: begin
            if (stat.full) begin
              status_code_next = ST_FULL;
            end else begin
              ctl.idx_op = IDX_COUNT;
              state_next = S_INS_CHK;
            end
          end
          CMD_REMOVE: begin
            if (stat.empty) begin
              status_code_next = ST_EMPTY;
            end else begin
              ctl.idx_op = IDX_ZERO;
              state_next = S_REM_RD;
            end
          end
          CMD_CLEAR: begin
            ctl.cnt_op = CNT_CLR;
          end
          default: begin
          end
        endcase
      end
      S_INS_CHK: begin
        if (stat.idx_zero) begin
          ctl.wr_en  = 1'b1;
          ctl.wd_sel = WD_VALUE;
          ctl.cnt_op = CNT_INC;
          state_next = S_MED_RD;
        end else begin
          ctl.rd_en  = 1'b1;
          ctl.rd_sel = RA_PREV;
          state_next = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        ctl.wr_en = 1'b1;
        if (stat.rd_gt) begin
          ctl.wd_sel = WD_RDATA;
          ctl.idx_op = IDX_DEC;
          state_next = S_INS_CHK;
        end else begin
          ctl.wd_sel = WD_VALUE;
          ctl.cnt_op = CNT_INC;
          state_next = S_MED_RD;
        end
      end
      S_REM_RD: begin
        ctl.rd_en  = 1'b1;
        ctl.rd_sel = RA_CUR;
        state_next = S_REM_CMP;
      end
      S_REM_CMP: begin
        if (stat.rd_ge || stat.idx_last) begin
          state_next = S_SH_CHK;
        end else begin
          ctl.idx_op = IDX_INC;
          state_next = S_REM_RD;
        end
      end
      S_SH_CHK: begin
        if (stat.idx_last) begin
          ctl.cnt_op = CNT_DEC;
          state_next = S_MED_RD;
        end else begin
          ctl.rd_en  = 1'b1;
          ctl.rd_sel = RA_NEXT;
          state_next = S_SH_WR;
        end
      end
      S_SH_WR: begin
        ctl.wr_en  = 1'b1;
        ctl.wd_sel = WD_RDATA;
        ctl.idx_op = IDX_INC;
        state_next = S_SH_CHK;
      end
      S_MED_RD: begin
        ctl.rd_en  = 1'b1;
        ctl.rd_sel = RA_HALF;
        state_next = S_MED_WAIT;
      end
      S_MED_WAIT: begin
        if (!stat.out_busy) begin
          ctl.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      status_code <= ST_OK;
    end else begin
      state       <= state_next;
      status_code <= status_code_next;
    end
  end

endmodule

/* rtl/swm_datapath.sv */
module swm_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [1:0]                    cmd,
  input  logic [swm_pkg::VALUE_W-1:0]   value,
  input  swm_pkg::ctl_t                 ctl,
  output swm_pkg::stat_t                stat,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [swm_pkg::VALUE_W-1:0]   median,
  output logic [swm_pkg::ENTRIES_W-1:0] entries,
  output logic [1:0]                    status
);
  import swm_pkg::*;

  logic [VALUE_W-1:0] mem [WINDOW_DEPTH];
  logic [VALUE_W-1:0] rdata;
  logic [VALUE_W-1:0] wdata;
  logic [1:0]         cmd_q;
  logic [VALUE_W-1:0] value_q;
  logic [CNT_W-1:0]   idx;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   idx_prev, idx_succ, count_half;
  logic [IDX_W-1:0]   raddr;
  logic [IDX_W-1:0]   waddr;

  assign idx_prev   = idx - CNT_W'(1);
  assign idx_succ   = idx + CNT_W'(1);
  assign count_half = count >> 1;
  assign waddr      = idx[IDX_W-1:0];
  assign wdata      = (ctl.wd_sel == WD_RDATA) ? rdata : value_q;

  always_comb begin
    case (ctl.rd_sel)
      RA_PREV: raddr = idx_prev[IDX_W-1:0];
      RA_CUR:  raddr = idx[IDX_W-1:0];
      RA_NEXT: raddr = idx_succ[IDX_W-1:0];
      RA_HALF: raddr = count_half[IDX_W-1:0];
      default: raddr = idx[IDX_W-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[waddr] <= wdata;
    end
    if (ctl.rd_en) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q   <= cmd;
      value_q <= value;
    end
    case (ctl.idx_op)
      IDX_COUNT: idx <= count;
      IDX_ZERO:  idx <= '0;
      IDX_INC:   idx <= idx_succ;
      IDX_DEC:   idx <= idx_prev;
      default:   idx <= idx;
    endcase
    if (ctl.out_load) begin
      median  <= (count != '0) ? rdata : '0;
      entries <= ENTRIES_W'(count);
      status  <= ctl.out_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      case (ctl.cnt_op)
        CNT_INC: count <= count + CNT_W'(1);
        CNT_DEC: count <= count - CNT_W'(1);
        CNT_CLR: count <= '0;
        default: count <= count;
      endcase
      if (ctl.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign stat.cmd      = cmd_q;
  assign stat.full     = (count == CNT_W'(WINDOW_DEPTH));
  assign stat.empty    = (count == '0);
  assign stat.idx_zero = (idx == '0);
  assign stat.idx_last = (idx_succ == count);
  assign stat.rd_gt    = (rdata > value_q);
  assign stat.rd_ge    = (rdata >= value_q);
  assign stat.out_busy = out_valid && !out_ready;

endmodule

/* rtl/sorted_window_median.sv */
// Sorted window median.
// Input channel (in_valid/in_ready) carries one request: cmd and value.
// cmd insert adds value after any equal entries, remove deletes the first
// entry not below value (or the last entry), clear empties the window.
// Output channel (out_valid/out_ready) returns one result per request:
// median (entry at index entries/2, 0 when empty), entries, and status
// (ok, insert ignored when full, remove ignored when empty).
// One request is processed at a time. The window lives in a single-port
// read / single-port write memory with registered read data, and entries
// are moved or examined one at a time through that port: insert walks
// down from the top shifting larger entries, remove scans up to the
// victim and then shifts the tail down. The next request can be accepted
// as soon as the result is presented.
// Reset empties the window at once; no clearing pass is needed.
// The result sits in an output register, so the next request is accepted
// while it waits. If the receiver stalls and that register is still
// full when the following result is ready, processing holds until it is
// taken.
module sorted_window_median (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    cmd,
  input  logic [swm_pkg::VALUE_W-1:0]   value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [swm_pkg::VALUE_W-1:0]   median,
  output logic [swm_pkg::ENTRIES_W-1:0] entries,
  output logic [1:0]                    status
);
  import swm_pkg::*;

  ctl_t  ctl;
  stat_t stat;

  swm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  swm_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .value     (value),
    .ctl       (ctl),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .median    (median),
    .entries   (entries),
    .status    (status)
  );

endmodule

/* tb/tb_sorted_window_median.sv */
module tb_sorted_window_median;
  import swm_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned LIMIT_CYCLES = 2_000_000;
  localparam int TARGET_REQUESTS = 2000;
  localparam int DRAIN_CYCLES = 2 * WINDOW_DEPTH + 20;

  typedef struct packed {
    logic [VALUE_W-1:0]   median;
    logic [ENTRIES_W-1:0] entries;
    logic [1:0]           status;
  } window_result_t;

  typedef struct packed {
    logic           pinned;
    window_result_t want;
  } pin_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [VALUE_W-1:0] val;
    pin_t               pin;
  } dir_row_t;

  typedef enum int {
    PH_FILL_DRAIN,
    PH_MIXED,
    PH_FILL_CLEAR
  } phase_kind_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           cmd = CMD_INSERT;
  logic [VALUE_W-1:0]   value = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [VALUE_W-1:0]   median;
  logic [ENTRIES_W-1:0] entries;
  logic [1:0]           status;

  sorted_window_median i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .median    (median),
    .entries   (entries),
    .status    (status)
  );

  always #5 clk = ~clk;

  // shadow window
  logic [VALUE_W-1:0] win [WINDOW_DEPTH];
  int                 win_cnt = 0;

  window_result_t median_due[$];
  pin_t           pinned_results[$];
  logic [VALUE_W-1:0] recent_vals[$];

  int          errors = 0;
  int          sent = 0;
  bit          brisk = 1'b0;
  int unsigned cycles = 0;

  dir_row_t dir_rows [24] = '{
    '{CMD_REMOVE, 32'd5,          '{1'b1, '{32'd0, 7'd0, ST_EMPTY}}},
    '{CMD_UNUSED, 32'd0,          '{1'b1, '{32'd0, 7'd0, ST_OK}}},
    '{CMD_INSERT, 32'd0,          '{1'b1, '{32'd0, 7'd1, ST_OK}}},
    '{CMD_INSERT, 32'hFFFF_FFFF,  '{1'b1, '{32'hFFFF_FFFF, 7'd2, ST_OK}}},
    '{CMD_INSERT, 32'd0,          '{1'b1, '{32'd0, 7'd3, ST_OK}}},
    '{CMD_REMOVE, 32'hFFFF_FFFF,  '{1'b1, '{32'd0, 7'd2, ST_OK}}},
    '{CMD_CLEAR,  32'd0,          '{1'b1, '{32'd0, 7'd0, ST_OK}}},
    '{CMD_INSERT, 32'd100,        '0},
    '{CMD_INSERT, 32'd50,         '0},
    '{CMD_INSERT, 32'd100,        '0},
    '{CMD_INSERT, 32'd200,        '0},
    '{CMD_INSERT, 32'd75,         '0},
    // absent, above all: last entry goes
    '{CMD_REMOVE, 32'd300,        '0},
    // absent, in between: next larger goes
    '{CMD_REMOVE, 32'd60,         '0},
    '{CMD_REMOVE, 32'd100,        '0},
    '{CMD_INSERT, 32'hAAAA_AAAA,  '0},
    '{CMD_INSERT, 32'h5555_5555,  '0},
    '{CMD_INSERT, 32'h8000_0000,  '0},
    '{CMD_INSERT, 32'h7FFF_FFFF,  '0},
    '{CMD_UNUSED, 32'hFFFF_FFFF,  '0},
    '{CMD_CLEAR,  32'h1234_5678,  '{1'b1, '{32'd0, 7'd0, ST_OK}}},
    '{CMD_REMOVE, 32'd0,          '{1'b1, '{32'd0, 7'd0, ST_EMPTY}}},
    '{CMD_INSERT, 32'd1,          '{1'b1, '{32'd1, 7'd1, ST_OK}}},
    '{CMD_CLEAR,  32'hFFFF_FFFF,  '{1'b1, '{32'd0, 7'd0, ST_OK}}}
  };

  function automatic window_result_t update_window(logic [1:0] op, logic [VALUE_W-1:0] v);
    window_result_t r;
    int pos;
    int i;
    r.status = ST_OK;
    case (op)
      CMD_INSERT: begin
        if (win_cnt >= WINDOW_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < win_cnt && win[pos] <= v) pos++;
          for (i = win_cnt; i > pos; i--) win[i] = win[i-1];
          win[pos] = v;
          win_cnt++;
        end
      end
      CMD_REMOVE: begin
        if (win_cnt == 0) begin
          r.status = ST_EMPTY;
        end else begin
          pos = 0;
          while (pos < win_cnt && win[pos] < v) pos++;
          if (pos >= win_cnt) pos = win_cnt - 1;
          for (i = pos; i + 1 < win_cnt; i++) win[i] = win[i+1];
          win_cnt--;
        end
      end
      CMD_CLEAR: win_cnt = 0;
      default: ;
    endcase
    r.median = (win_cnt != 0) ? win[win_cnt/2] : '0;
    r.entries = ENTRIES_W'(win_cnt);
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [VALUE_W-1:0] got,
                               input logic [VALUE_W-1:0] want);
    $display("[%0t] mismatch %s: got 0x%0h want 0x%0h", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin : monitor
    pin_t           pin;
    window_result_t exp;
    if (!rst) begin
      if (in_valid && in_ready) begin
        pin = pinned_results.pop_front();
        exp = update_window(cmd, value);
        if (pin.pinned) exp = pin.want;
        median_due.push_back(exp);
      end
      if (out_valid && out_ready) begin
        if (median_due.size() == 0) begin
          flag_mismatch("result with no request outstanding", median, '0);
        end else begin
          exp = median_due.pop_front();
          if (median !== exp.median) flag_mismatch("median", median, exp.median);
          if (entries !== exp.entries)
            flag_mismatch("entries", VALUE_W'(entries), VALUE_W'(exp.entries));
          if (status !== exp.status)
            flag_mismatch("status", VALUE_W'(status), VALUE_W'(exp.status));
        end
      end
    end
  end

  // receiver: mostly ready, short and long stalls, calm stretches
  int rx_hold = 0;
  int rx_calm = 0;
  always @(posedge clk) begin : receiver
    int r;
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      out_ready <= 1'b0;
    end else if (rx_calm > 0) begin
      rx_calm <= rx_calm - 1;
      out_ready <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        out_ready <= 1'b1;
      end else if (r < 85) begin
        out_ready <= 1'b0;
        rx_hold <= $urandom_range(0, 2);
      end else if (r < 95) begin
        out_ready <= 1'b0;
        rx_hold <= $urandom_range(5, 40);
      end else begin
        out_ready <= 1'b1;
        rx_calm <= $urandom_range(50, 300);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("sorted_window_median regression: fail");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    if (brisk) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value(bit from_pool);
    int r;
    r = $urandom_range(0, 9);
    if (from_pool && recent_vals.size() != 0 && r < 5)
      return recent_vals[$urandom_range(0, recent_vals.size() - 1)];
    if (r < 4) return $urandom_range(0, 15);
    if (r < 8) return $urandom;
    case ($urandom_range(0, 3))
      0: return 32'd0;
      1: return 32'd1;
      2: return 32'hFFFF_FFFE;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  task automatic send_request(input logic [1:0] op, input logic [VALUE_W-1:0] v,
                              input pin_t pin);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    pinned_results.push_back(pin);
    in_valid <= 1'b1;
    cmd <= op;
    value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
    if (op == CMD_INSERT) begin
      recent_vals.push_back(v);
      if (recent_vals.size() > WINDOW_DEPTH) void'(recent_vals.pop_front());
    end
  endtask

  task automatic random_request();
    int r;
    r = $urandom_range(0, 99);
    if (r < 48) send_request(CMD_INSERT, pick_value(1'b0), '0);
    else if (r < 90) send_request(CMD_REMOVE, pick_value(1'b1), '0);
    else if (r < 95) send_request(CMD_CLEAR, $urandom, '0);
    else send_request(CMD_UNUSED, $urandom, '0);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk);
    while (median_due.size() != 0 || pinned_results.size() != 0);
  endtask

  initial begin
    int i;
    int n;
    phase_kind_t ph;
    bit first_phase;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[k]) send_request(dir_rows[k].op, dir_rows[k].val, dir_rows[k].pin);

    first_phase = 1'b1;
    while (sent < TARGET_REQUESTS) begin
      ph = first_phase ? PH_FILL_DRAIN : phase_kind_t'($urandom_range(0, 2));
      brisk = ($urandom_range(0, 3) == 0);
      case (ph)
        PH_FILL_DRAIN: begin
          n = WINDOW_DEPTH + $urandom_range(1, 4);
          for (i = 0; i < n; i++) send_request(CMD_INSERT, pick_value(1'b0), '0);
          n = WINDOW_DEPTH + $urandom_range(1, 4);
          for (i = 0; i < n; i++) send_request(CMD_REMOVE, pick_value(1'b1), '0);
        end
        PH_MIXED: begin
          n = $urandom_range(30, 120);
          for (i = 0; i < n; i++) random_request();
        end
        default: begin
          n = $urandom_range(1, WINDOW_DEPTH);
          for (i = 0; i < n; i++) send_request(CMD_INSERT, pick_value(1'b0), '0);
          send_request(CMD_CLEAR, $urandom, '0);
        end
      endcase
      // after the first phase, and at random after others, hold off until the block has answered everything
      if (first_phase || $urandom_range(0, 4) == 0) settle();
      first_phase = 1'b0;
    end

    brisk = 1'b0;
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("sorted_window_median regression: pass");
    end else begin
      $display("sorted_window_median regression: fail");
    end
    $finish;
  end

endmodule
